FILE: hdl/cansrt_pkg.sv
// ----------------------------------------------------------------------------
// cansrt_pkg: shared types and constants of the CAN setting request tracker
// Holds the event and status codes, verdict codes, register indexes and the
// fixed frame identifiers and opcodes of the setting protocol.
// ----------------------------------------------------------------------------
`default_nettype none

package cansrt_pkg;

  // Event codes carried in the input tuser.
  typedef enum logic [2:0] {
    CMD_HOST   = 3'd0,
    CMD_PRE_TX = 3'd1,
    CMD_TX_END = 3'd2,
    CMD_RX     = 3'd3,
    CMD_POLL   = 3'd4
  } cmd_t;

  // Request status codes.
  typedef enum logic [3:0] {
    ST_READY     = 4'd0,
    ST_INVALID   = 4'd1,
    ST_BUSY      = 4'd2,
    ST_DUPLICATE = 4'd3,
    ST_QUEUED    = 4'd4,
    ST_QFULL     = 4'd5,
    ST_STARTED   = 4'd6,
    ST_FAILED    = 4'd7,
    ST_TIMEOUT   = 4'd8,
    ST_MATCHED   = 4'd9
  } status_t;

  // Transmit verdict codes.
  typedef enum logic [1:0] {
    TXV_NOT_OURS = 2'd0,
    TXV_SEND     = 2'd1,
    TXV_DROP     = 2'd2
  } verdict_t;

  // Result kind codes carried in the output tuser.
  localparam logic RK_HOST_REPLY = 1'b0;
  localparam logic RK_TX_VERDICT = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_PACKET_TYPE   = 3'd0;
  localparam logic [2:0] REG_BODY_LENGTH   = 3'd1;
  localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd2;
  localparam logic [2:0] REG_HELLO_KIND    = 3'd3;
  localparam logic [2:0] REG_STATUS_KIND   = 3'd4;
  localparam logic [2:0] REG_SET_KIND      = 3'd5;

  // Protocol constants.
  localparam logic [28:0] REQ_FRAME_ID   = 29'h16305054;
  localparam logic [28:0] ACK_FRAME_ID   = 29'h16305450;
  localparam logic [7:0]  REQ_OPCODE     = 8'h40;
  localparam logic [7:0]  ACK_OPCODE     = 8'hC0;
  localparam logic [39:0] HDR_SIGNATURE  = 40'h0B48435801;
  localparam logic [7:0]  HELLO_FEATURE  = 8'h01;
  localparam logic [7:0]  HELLO_VALUE    = 8'h0F;
  localparam logic [7:0]  MENU_F1        = 8'h15;
  localparam logic [7:0]  MENU_F2        = 8'h20;
  localparam logic [7:0]  MENU_F3        = 8'h32;
  localparam logic [7:0]  MENU_F4        = 8'h33;
  localparam logic [2:0]  CAN_IDE_EXT    = 3'd4;
  localparam logic [3:0]  CAN_DLC_REQ    = 4'd3;
  localparam logic [7:0]  MAX_START_MBOX = 8'd3;

  // Reset values of the configuration registers.
  localparam logic [7:0]  RST_PACKET_TYPE   = 8'd0;
  localparam logic [7:0]  RST_BODY_LENGTH   = 8'd13;
  localparam logic [31:0] RST_TIMEOUT_TICKS = 32'd1000;
  localparam logic [7:0]  RST_HELLO_KIND    = 8'd1;
  localparam logic [7:0]  RST_STATUS_KIND   = 8'd2;
  localparam logic [7:0]  RST_SET_KIND      = 8'd3;

  // One result word before packing.
  typedef struct packed {
    logic     kind;
    status_t  status;
    logic [31:0] id;
    logic [7:0]  feature;
    logic [7:0]  value;
    verdict_t    verdict;
  } result_t;

endpackage : cansrt_pkg

`default_nettype wire

FILE: hdl/can_setting_request_tracker_top.sv
// ----------------------------------------------------------------------------
// can_setting_request_tracker_top: single setting request tracker
// Takes one event word per cycle, tracks one outstanding setting request and
// emits host replies, transmit verdicts and published status changes.
// ----------------------------------------------------------------------------
// The tracker accepts one event word per clock cycle. An accepted word lands
// in an input register; in the following cycle a short block of compare and
// update logic evaluates it against the tracked request, updates the request
// state and, when the event calls for a result, loads the output register.
// A result word is valid on the output from the edge at which the evaluation
// loads it into the output register. The only thing that slows the input is
// back-pressure on the result side: an event that produces a result waits in
// the input register while the output register is full and not being drained,
// and events that produce no result never wait. The single 32-bit wrapping
// subtract and compare of the expiry check sets the critical path.
// Configuration registers are written through the plain write port and must
// only be changed while the tracker is idle.
`default_nettype none

module can_setting_request_tracker_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Input event stream.
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // in_tdata, from bit 0: now[31:0], packet_length[39:32],
  // header_bytes[87:40], message_kind[95:88], transaction_id[127:96],
  // feature[135:128], api[143:136], enqueue_accepted[144],
  // frame_id[173:145], frame_control[181:174], frame_data[205:182],
  // zero padding[207:206].
  input  wire logic [207:0] in_tdata,
  // in_tuser: command[2:0].
  input  wire logic [2:0]   in_tuser,
  // Result stream.
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_tdata, from bit 0: reply_status[3:0], reply_id[35:4],
  // reply_feature[43:36], reply_value[51:44], tx_verdict[53:52],
  // zero padding[55:54].
  output logic [55:0]       out_tdata,
  // out_tuser: result_kind[0].
  output logic              out_tuser,
  // Configuration write port.
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata
);

  import cansrt_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0]  packet_type_r;
  logic [7:0]  body_length_r;
  logic [31:0] timeout_ticks_r;
  logic [7:0]  hello_kind_r;
  logic [7:0]  status_kind_r;
  logic [7:0]  set_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packet_type_r   <= RST_PACKET_TYPE;
      body_length_r   <= RST_BODY_LENGTH;
      timeout_ticks_r <= RST_TIMEOUT_TICKS;
      hello_kind_r    <= RST_HELLO_KIND;
      status_kind_r   <= RST_STATUS_KIND;
      set_kind_r      <= RST_SET_KIND;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PACKET_TYPE:   packet_type_r   <= cfg_wdata[7:0];
        REG_BODY_LENGTH:   body_length_r   <= cfg_wdata[7:0];
        REG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_wdata;
        REG_HELLO_KIND:    hello_kind_r    <= cfg_wdata[7:0];
        REG_STATUS_KIND:   status_kind_r   <= cfg_wdata[7:0];
        REG_SET_KIND:      set_kind_r      <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic          s1_valid_r;
  logic [2:0]    s1_cmd_r;
  logic [205:0]  s1_data_r;
  logic          s1_fire;

  assign in_tready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r  <= in_tuser;
      s1_data_r <= in_tdata[205:0];
    end
  end

  // Field views of the registered word.
  logic [31:0] f_now;
  logic [7:0]  f_len;
  logic [47:0] f_hdr;
  logic [7:0]  f_kind;
  logic [31:0] f_id;
  logic [7:0]  f_feature;
  logic [7:0]  f_api;
  logic        f_acc;
  logic [28:0] f_fid;
  logic [7:0]  f_ctrl;
  logic [23:0] f_fdata;

  assign f_now     = s1_data_r[31:0];
  assign f_len     = s1_data_r[39:32];
  assign f_hdr     = s1_data_r[87:40];
  assign f_kind    = s1_data_r[95:88];
  assign f_id      = s1_data_r[127:96];
  assign f_feature = s1_data_r[135:128];
  assign f_api     = s1_data_r[143:136];
  assign f_acc     = s1_data_r[144];
  assign f_fid     = s1_data_r[173:145];
  assign f_ctrl    = s1_data_r[181:174];
  assign f_fdata   = s1_data_r[205:182];

  // --------------------------------------------------------------------------
  // Request state
  // --------------------------------------------------------------------------
  logic [31:0] active_id_r,      active_id_nxt;
  logic [7:0]  stored_feature_r, stored_feature_nxt;
  logic [7:0]  stored_api_r,     stored_api_nxt;
  logic [31:0] start_time_r,     start_time_nxt;
  logic        owned_r,          owned_nxt;
  status_t     cur_status_r,     cur_status_nxt;
  status_t     pub_status_r,     pub_status_nxt;
  logic [7:0]  frame_menu_r,     frame_menu_nxt;
  logic [7:0]  frame_value_r,    frame_value_nxt;

  // --------------------------------------------------------------------------
  // Event evaluation
  // --------------------------------------------------------------------------
  logic        expired;
  status_t     aged_status;
  logic        shape_ok;
  logic        hdr_pass;
  logic        hdr_ok;
  logic        map_ok;
  logic [7:0]  map_menu;
  logic [7:0]  map_value;
  logic        res_valid;
  result_t     res;

  // Age is taken modulo 2^32, so the tick counter may wrap freely.
  assign expired  = (f_now - start_time_r) >= timeout_ticks_r;
  assign shape_ok = (f_ctrl[7:5] == CAN_IDE_EXT) && !f_ctrl[0]
                    && (f_ctrl[4:1] == CAN_DLC_REQ);
  assign hdr_pass = (f_len != 8'd0) && (f_hdr[47:40] == packet_type_r);
  assign hdr_ok   = (f_len == body_length_r) && (f_hdr[39:0] == HDR_SIGNATURE);

  // A queued or started request that has run out of time reads as timeout.
  always_comb begin
    aged_status = cur_status_r;
    if ((cur_status_r == ST_QUEUED || cur_status_r == ST_STARTED) && expired) begin
      aged_status = ST_TIMEOUT;
    end
  end

  // Feature and value byte to menu and value of the CAN request frame.
  always_comb begin
    map_ok    = 1'b0;
    map_menu  = 8'd0;
    map_value = 8'd0;
    case (f_feature)
      8'd1: begin
        map_ok    = (f_api >= 8'd1) && (f_api <= 8'd3);
        map_menu  = MENU_F1;
        map_value = f_api - 8'd1;
      end
      8'd2: begin
        map_ok    = (f_api >= 8'd1) && (f_api <= 8'd2);
        map_menu  = MENU_F2;
        map_value = f_api - 8'd1;
      end
      8'd3: begin
        map_ok    = (f_api >= 8'd1) && (f_api <= 8'd7);
        map_menu  = MENU_F3;
        map_value = f_api;
      end
      8'd4: begin
        map_ok    = (f_api >= 8'd1) && (f_api <= 8'd8);
        map_menu  = MENU_F4;
        map_value = (f_api == 8'd1) ? 8'd7 : f_api - 8'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    active_id_nxt      = active_id_r;
    stored_feature_nxt = stored_feature_r;
    stored_api_nxt     = stored_api_r;
    start_time_nxt     = start_time_r;
    owned_nxt          = owned_r;
    cur_status_nxt     = cur_status_r;
    pub_status_nxt     = pub_status_r;
    frame_menu_nxt     = frame_menu_r;
    frame_value_nxt    = frame_value_r;
    res_valid          = 1'b0;
    res                = '{kind: RK_HOST_REPLY, status: ST_READY, id: 32'd0,
                           feature: 8'd0, value: 8'd0, verdict: TXV_NOT_OURS};

    case (cmd_t'(s1_cmd_r))
      CMD_HOST: begin
        if (hdr_pass) begin
          res_valid = 1'b1;
          if (!hdr_ok) begin
            res.status = ST_INVALID;
          end else if (f_kind == hello_kind_r && f_feature == 8'd0 && f_api == 8'd0) begin
            res.status  = ST_READY;
            res.id      = f_id;
            res.feature = HELLO_FEATURE;
            res.value   = HELLO_VALUE;
          end else if (f_kind == status_kind_r && f_feature == 8'd0 && f_api == 8'd0
                       && f_id != 32'd0 && f_id == active_id_r) begin
            cur_status_nxt = aged_status;
            res.status     = aged_status;
            res.id         = f_id;
            res.feature    = stored_feature_r;
            res.value      = stored_api_r;
          end else if (f_kind != set_kind_r || f_id == 32'd0 || !map_ok) begin
            res.status = ST_INVALID;
          end else begin
            res.id      = f_id;
            res.feature = f_feature;
            res.value   = f_api;
            if (owned_r || cur_status_r == ST_STARTED) begin
              res.status = ST_BUSY;
            end else if (f_id == active_id_r) begin
              res.status = ST_DUPLICATE;
            end else begin
              frame_menu_nxt     = map_menu;
              frame_value_nxt    = map_value;
              active_id_nxt      = f_id;
              stored_feature_nxt = f_feature;
              stored_api_nxt     = f_api;
              start_time_nxt     = f_now;
              owned_nxt          = f_acc;
              cur_status_nxt     = f_acc ? ST_QUEUED : ST_QFULL;
              pub_status_nxt     = cur_status_nxt;
              res.status         = cur_status_nxt;
            end
          end
        end
      end
      CMD_PRE_TX: begin
        res_valid = 1'b1;
        res.kind  = RK_TX_VERDICT;
        if (owned_r && shape_ok && f_fid == REQ_FRAME_ID
            && f_fdata == {REQ_OPCODE, frame_menu_r, frame_value_r}) begin
          if (cur_status_r == ST_TIMEOUT || expired) begin
            owned_nxt      = 1'b0;
            cur_status_nxt = ST_TIMEOUT;
            res.verdict    = TXV_DROP;
          end else begin
            res.verdict    = TXV_SEND;
          end
        end
      end
      CMD_TX_END: begin
        if (owned_r) begin
          owned_nxt      = 1'b0;
          cur_status_nxt = (f_api < MAX_START_MBOX) ? ST_STARTED : ST_FAILED;
          start_time_nxt = f_now;
        end
      end
      CMD_RX: begin
        if (cur_status_r == ST_STARTED) begin
          if (expired) begin
            cur_status_nxt = ST_TIMEOUT;
          end else if (f_fid == ACK_FRAME_ID && shape_ok
                       && f_fdata == {ACK_OPCODE, frame_menu_r, frame_value_r}) begin
            cur_status_nxt = ST_MATCHED;
          end
        end
      end
      CMD_POLL: begin
        cur_status_nxt = aged_status;
        if (pub_status_r != aged_status) begin
          pub_status_nxt = aged_status;
          res_valid      = 1'b1;
          res.status     = aged_status;
          res.id         = active_id_r;
          res.feature    = stored_feature_r;
          res.value      = stored_api_r;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register and state update
  // --------------------------------------------------------------------------
  logic    out_valid_r;
  result_t out_res_r;
  logic    out_free;

  // The word in the input register leaves once its result has somewhere to go.
  assign out_free = !out_valid_r || out_tready;
  assign s1_fire  = s1_valid_r && (!res_valid || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_id_r      <= 32'd0;
      stored_feature_r <= 8'd0;
      stored_api_r     <= 8'd0;
      start_time_r     <= 32'd0;
      owned_r          <= 1'b0;
      cur_status_r     <= ST_READY;
      pub_status_r     <= ST_READY;
      frame_menu_r     <= 8'd0;
      frame_value_r    <= 8'd0;
    end else if (s1_fire) begin
      active_id_r      <= active_id_nxt;
      stored_feature_r <= stored_feature_nxt;
      stored_api_r     <= stored_api_nxt;
      start_time_r     <= start_time_nxt;
      owned_r          <= owned_nxt;
      cur_status_r     <= cur_status_nxt;
      pub_status_r     <= pub_status_nxt;
      frame_menu_r     <= frame_menu_nxt;
      frame_value_r    <= frame_value_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {2'b00, out_res_r.verdict, out_res_r.value, out_res_r.feature,
                       out_res_r.id, out_res_r.status};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // A frame still owned in the transmit queue belongs to a queued request,
  // or to one that aged out before the transmitter looked at it.
  a_owned_status: assert property (@(posedge clk) disable iff (!rst_n)
    owned_r |-> (cur_status_r == ST_QUEUED || cur_status_r == ST_TIMEOUT))
    else $error("owned frame with unexpected request status");

  // Reply-only codes never become the tracked request status.
  a_status_kind: assert property (@(posedge clk) disable iff (!rst_n)
    cur_status_r != ST_INVALID && cur_status_r != ST_BUSY
    && cur_status_r != ST_DUPLICATE)
    else $error("tracked status holds a reply-only code");

  // Host replies never carry a transmit verdict.
  a_reply_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == RK_HOST_REPLY) |-> out_tdata[53:52] == TXV_NOT_OURS)
    else $error("host reply carries a transmit verdict");

  // An input word that makes no result never waits in the input register.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !res_valid) |-> s1_fire)
    else $error("resultless word stalled");
`endif

endmodule : can_setting_request_tracker_top

`default_nettype wire

FILE: verif/tb_can_setting_request_tracker_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_can_setting_request_tracker_top: self-checking bench of the request tracker
// Drives host packets, transmit checks, transmit-done notices, received frames
// and poll ticks through the event stream. A scoreboard predicts every host
// reply and transmit verdict and checks the result stream in order, across
// several register settings and with random idling on both sides.
// ----------------------------------------------------------------------------

module tb_can_setting_request_tracker_top;
  import cansrt_pkg::*;

  // Command codes that the tracker does not know and must ignore.
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  // Fields of one event word before packing into in_tdata.
  typedef struct {
    logic [31:0] now;
    logic [7:0]  len;
    logic [47:0] hdr;
    logic [7:0]  kind;
    logic [31:0] id;
    logic [7:0]  feature;
    logic [7:0]  api;
    logic        acc;
    logic [28:0] fid;
    logic [7:0]  ctrl;
    logic [23:0] data;
  } tracker_event_t;

  // The scoreboard keeps its own copy of the registers and of the tracked
  // request, and holds the replies and verdicts that are still owed.
  class request_scoreboard;
    logic [7:0]  cfg_type, cfg_len, cfg_hello, cfg_query, cfg_set;
    logic [31:0] cfg_timeout;
    logic [31:0] req_id, req_since;
    logic [7:0]  req_feature, req_choice, tx_menu, tx_value;
    bit          in_queue;
    status_t     req_status, shown_status;
    result_t     pending_replies[$];
    int          errors;

    function void clear();
      cfg_type     = RST_PACKET_TYPE;
      cfg_len      = RST_BODY_LENGTH;
      cfg_timeout  = RST_TIMEOUT_TICKS;
      cfg_hello    = RST_HELLO_KIND;
      cfg_query    = RST_STATUS_KIND;
      cfg_set      = RST_SET_KIND;
      req_id       = '0;
      req_since    = '0;
      req_feature  = '0;
      req_choice   = '0;
      tx_menu      = '0;
      tx_value     = '0;
      in_queue     = 1'b0;
      req_status   = ST_READY;
      shown_status = ST_READY;
      pending_replies.delete();
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        REG_PACKET_TYPE:   cfg_type    = d[7:0];
        REG_BODY_LENGTH:   cfg_len     = d[7:0];
        REG_TIMEOUT_TICKS: cfg_timeout = d;
        REG_HELLO_KIND:    cfg_hello   = d[7:0];
        REG_STATUS_KIND:   cfg_query   = d[7:0];
        REG_SET_KIND:      cfg_set     = d[7:0];
        default: ;
      endcase
    endfunction

    // Elapsed ticks wrap at 32 bits, so the age is a plain modular subtract.
    function bit lapsed(logic [31:0] now);
      logic [31:0] age;
      age = now - req_since;
      return age >= cfg_timeout;
    endfunction

    function void age_out(logic [31:0] now);
      if ((req_status == ST_QUEUED || req_status == ST_STARTED) && lapsed(now))
        req_status = ST_TIMEOUT;
    endfunction

    function void expect_reply(status_t st, logic [31:0] id, logic [7:0] f, logic [7:0] v);
      result_t r;
      r.kind    = RK_HOST_REPLY;
      r.status  = st;
      r.id      = id;
      r.feature = f;
      r.value   = v;
      r.verdict = TXV_NOT_OURS;
      pending_replies.push_back(r);
    endfunction

    function bit frame_ok(logic [7:0] ctrl);
      return ctrl[0] == 1'b0 && ctrl[4:1] == CAN_DLC_REQ && ctrl[7:5] == CAN_IDE_EXT;
    endfunction

    // Translates a feature and its requested choice into the menu and value
    // bytes of the outgoing frame.
    function bit map_setting(logic [7:0] f, logic [7:0] a,
                             output logic [7:0] menu, output logic [7:0] v);
      menu = '0;
      v    = '0;
      case (f)
        8'd1: begin
          menu = MENU_F1;
          v    = a - 8'd1;
          return a >= 8'd1 && a <= 8'd3;
        end
        8'd2: begin
          menu = MENU_F2;
          v    = a - 8'd1;
          return a >= 8'd1 && a <= 8'd2;
        end
        8'd3: begin
          menu = MENU_F3;
          v    = a;
          return a >= 8'd1 && a <= 8'd7;
        end
        8'd4: begin
          menu = MENU_F4;
          v    = (a == 8'd1) ? 8'd7 : a - 8'd1;
          return a >= 8'd1 && a <= 8'd8;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void note_event(logic [2:0] cmd, logic [207:0] w);
      logic [31:0] now, id;
      logic [7:0]  len, kind, f, a, ctrl, menu, v;
      logic [47:0] hdr;
      logic        acc, mapped;
      logic [28:0] fid;
      logic [23:0] data;
      result_t     r;
      now  = w[31:0];
      len  = w[39:32];
      hdr  = w[87:40];
      kind = w[95:88];
      id   = w[127:96];
      f    = w[135:128];
      a    = w[143:136];
      acc  = w[144];
      fid  = w[173:145];
      ctrl = w[181:174];
      data = w[205:182];
      case (cmd)
        CMD_HOST: begin
          if (len == 8'd0 || hdr[47:40] != cfg_type) return;
          mapped = map_setting(f, a, menu, v);
          if (len != cfg_len || hdr[39:0] != HDR_SIGNATURE)
            expect_reply(ST_INVALID, '0, '0, '0);
          else if (kind == cfg_hello && f == 8'd0 && a == 8'd0)
            expect_reply(ST_READY, id, HELLO_FEATURE, HELLO_VALUE);
          else if (kind == cfg_query && f == 8'd0 && a == 8'd0 && id != '0 && id == req_id) begin
            age_out(now);
            expect_reply(req_status, id, req_feature, req_choice);
          end else if (kind != cfg_set || id == '0 || !mapped)
            expect_reply(ST_INVALID, '0, '0, '0);
          else if (in_queue || req_status == ST_STARTED)
            expect_reply(ST_BUSY, id, f, a);
          else if (id == req_id)
            expect_reply(ST_DUPLICATE, id, f, a);
          else begin
            tx_menu      = menu;
            tx_value     = v;
            req_id       = id;
            req_feature  = f;
            req_choice   = a;
            req_since    = now;
            in_queue     = acc;
            req_status   = acc ? ST_QUEUED : ST_QFULL;
            shown_status = req_status;
            expect_reply(req_status, id, f, a);
          end
        end
        CMD_PRE_TX: begin
          r.kind    = RK_TX_VERDICT;
          r.status  = ST_READY;
          r.id      = '0;
          r.feature = '0;
          r.value   = '0;
          r.verdict = TXV_NOT_OURS;
          if (in_queue && frame_ok(ctrl) && fid == REQ_FRAME_ID &&
              data == {REQ_OPCODE, tx_menu, tx_value}) begin
            if (req_status == ST_TIMEOUT || lapsed(now)) begin
              in_queue   = 1'b0;
              req_status = ST_TIMEOUT;
              r.verdict  = TXV_DROP;
            end else begin
              r.verdict = TXV_SEND;
            end
          end
          pending_replies.push_back(r);
        end
        CMD_TX_END: begin
          if (in_queue) begin
            in_queue   = 1'b0;
            req_status = (a < MAX_START_MBOX) ? ST_STARTED : ST_FAILED;
            req_since  = now;
          end
        end
        CMD_RX: begin
          if (req_status == ST_STARTED) begin
            if (lapsed(now))
              req_status = ST_TIMEOUT;
            else if (fid == ACK_FRAME_ID && frame_ok(ctrl) &&
                     data == {ACK_OPCODE, tx_menu, tx_value})
              req_status = ST_MATCHED;
          end
        end
        CMD_POLL: begin
          age_out(now);
          if (shown_status != req_status) begin
            shown_status = req_status;
            expect_reply(req_status, req_id, req_feature, req_choice);
          end
        end
        default: ;
      endcase
    endfunction

    // Prints one line for the mismatch and counts it.
    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(logic kind, logic [55:0] d);
      result_t want;
      if (pending_replies.size() == 0) begin
        report($sformatf("result word %h/%h with nothing expected", kind, d));
        return;
      end
      want = pending_replies.pop_front();
      if (kind !== want.kind)
        report($sformatf("result_kind got %b want %b", kind, want.kind));
      if (d[3:0] !== want.status)
        report($sformatf("reply_status got %0d want %0d", d[3:0], want.status));
      if (d[35:4] !== want.id)
        report($sformatf("reply_id got %h want %h", d[35:4], want.id));
      if (d[43:36] !== want.feature)
        report($sformatf("reply_feature got %h want %h", d[43:36], want.feature));
      if (d[51:44] !== want.value)
        report($sformatf("reply_value got %h want %h", d[51:44], want.value));
      if (d[53:52] !== want.verdict)
        report($sformatf("tx_verdict got %0d want %0d", d[53:52], want.verdict));
    endtask
  endclass

  // Every input of the tracker starts at a known value.
  logic         clk       = 1'b0;
  logic         rst_n     = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [207:0] in_tdata  = '0;
  logic [2:0]   in_tuser  = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [55:0]  out_tdata;
  logic         out_tuser;
  logic         cfg_we    = 1'b0;
  logic [2:0]   cfg_addr  = '0;
  logic [31:0]  cfg_wdata = '0;

  request_scoreboard tracker = new();

  // Tick counter that the stimulus carries in every event word, the largest
  // random advance per word, and a switch that turns idling off on both sides.
  logic [31:0] tick     = 32'd100;
  int unsigned step_max = 32'd20;
  bit          calm     = 1'b0;

  can_setting_request_tracker_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // The result side stalls about three times in ten unless the bench is
  // in a calm stretch.
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 30);
  end

  // Every result word taken at this edge is compared against the oldest
  // expectation. The values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (out_tvalid && out_tready) tracker.check_result(out_tuser, out_tdata);
  end

  // Presents one event word and returns at the edge where it is accepted.
  // The word is handed to the scoreboard at that same edge, so the next
  // word is always built from an up-to-date picture of the request.
  task automatic send_event(input logic [2:0] cmd, input tracker_event_t e);
    logic [207:0] word;
    word = {2'b00, e.data, e.ctrl, e.fid, e.acc, e.api, e.feature, e.id,
            e.kind, e.hdr, e.len, e.now};
    if (!calm && $urandom_range(99) < 20) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_event(cmd, word);
  endtask

  function automatic tracker_event_t blank_event();
    tracker_event_t e;
    e.now     = tick;
    e.len     = '0;
    e.hdr     = '0;
    e.kind    = '0;
    e.id      = '0;
    e.feature = '0;
    e.api     = '0;
    e.acc     = 1'b0;
    e.fid     = '0;
    e.ctrl    = '0;
    e.data    = '0;
    return e;
  endfunction

  // A well-formed host packet under the current register settings.
  function automatic tracker_event_t host_word(logic [7:0] kind, logic [31:0] id,
                                               logic [7:0] f, logic [7:0] a, logic acc);
    tracker_event_t e;
    e         = blank_event();
    e.len     = tracker.cfg_len;
    e.hdr     = {tracker.cfg_type, HDR_SIGNATURE};
    e.kind    = kind;
    e.id      = id;
    e.feature = f;
    e.api     = a;
    e.acc     = acc;
    return e;
  endfunction

  // The request frame, or the matching reply frame, of the tracked setting.
  function automatic tracker_event_t frame_word(bit ack);
    tracker_event_t e;
    e      = blank_event();
    e.fid  = ack ? ACK_FRAME_ID : REQ_FRAME_ID;
    e.ctrl = {CAN_IDE_EXT, CAN_DLC_REQ, 1'b0};
    e.data = {ack ? ACK_OPCODE : REQ_OPCODE, tracker.tx_menu, tracker.tx_value};
    return e;
  endfunction

  // Flips one bit of the identifier, the control byte or the data.
  function automatic tracker_event_t spoil_frame(tracker_event_t e);
    case ($urandom_range(2))
      0:       e.fid  = e.fid ^ (29'd1 << $urandom_range(28));
      1:       e.ctrl = e.ctrl ^ (8'd1 << $urandom_range(7));
      default: e.data = e.data ^ (24'd1 << $urandom_range(23));
    endcase
    return e;
  endfunction

  // One random event. Most words follow the life of a request (set, transmit
  // check, transmit done, reply frame, polls and queries) with random content,
  // the rest is noise and deliberately broken packets and frames.
  task automatic random_event();
    tracker_event_t e;
    logic [2:0]     cmd;
    logic [31:0]    id;
    int             pick, sub;
    tick = tick + $urandom_range(0, step_max);
    if ($urandom_range(99) < 3) tick = tick + tracker.cfg_timeout;
    pick = $urandom_range(99);
    e    = blank_event();
    if (pick < 10) begin
      cmd       = 3'($urandom_range(7));
      e.len     = 8'($urandom);
      e.hdr     = {16'($urandom), $urandom};
      e.kind    = 8'($urandom);
      e.id      = $urandom;
      e.feature = 8'($urandom);
      e.api     = 8'($urandom);
      e.acc     = 1'($urandom);
      e.fid     = 29'($urandom);
      e.ctrl    = 8'($urandom);
      e.data    = 24'($urandom);
      // Half of the noise gets past the packet type check.
      if ($urandom_range(1) == 1) e.hdr[47:40] = tracker.cfg_type;
    end else if (pick < 42) begin
      cmd = CMD_HOST;
      sub = $urandom_range(99);
      if (sub < 15) begin
        e = host_word(tracker.cfg_hello, $urandom, 8'd0, 8'd0, 1'($urandom));
      end else if (sub < 40) begin
        id = ($urandom_range(99) < 75) ? tracker.req_id : $urandom;
        e  = host_word(tracker.cfg_query, id, 8'd0, 8'd0, 1'($urandom));
      end else if (sub < 90) begin
        case ($urandom_range(19))
          0:       id = '0;
          1, 2, 3: id = tracker.req_id;
          4, 5:    id = 32'($urandom_range(1, 4));
          default: id = $urandom;
        endcase
        e = host_word(tracker.cfg_set, id, 8'($urandom_range(0, 5)),
                      8'($urandom_range(0, 9)), $urandom_range(99) < 80);
      end else begin
        e = host_word(8'($urandom), $urandom, 8'($urandom), 8'($urandom), 1'($urandom));
      end
      sub = $urandom_range(99);
      if (sub < 4)
        e.len = e.len + 8'($urandom_range(1, 255));
      else if (sub < 8)
        e.hdr[39:0] = e.hdr[39:0] ^ (40'd1 << $urandom_range(39));
      else if (sub < 10)
        e.hdr[47:40] = e.hdr[47:40] ^ 8'($urandom_range(1, 255));
    end else if (pick < 60) begin
      cmd = CMD_PRE_TX;
      e   = frame_word(1'b0);
      if ($urandom_range(99) < 20) e = spoil_frame(e);
    end else if (pick < 72) begin
      cmd   = CMD_TX_END;
      e.api = ($urandom_range(99) < 80) ? 8'($urandom_range(0, 5)) : 8'($urandom);
    end else if (pick < 85) begin
      cmd = CMD_RX;
      e   = frame_word(1'b1);
      if ($urandom_range(99) < 20) e = spoil_frame(e);
    end else begin
      cmd = CMD_POLL;
    end
    e.now = tick;
    send_event(cmd, e);
  endtask

  // Lowers the input valid and waits until every owed word has come out,
  // then lets the input and output registers run empty behind words that
  // owed nothing.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes all six registers one after another while the tracker is idle.
  task automatic configure(input logic [7:0] pt, input logic [7:0] bl,
                           input logic [31:0] tmo, input logic [7:0] hk,
                           input logic [7:0] sk, input logic [7:0] stk);
    logic [31:0] vals [6];
    vals[REG_PACKET_TYPE]   = {24'd0, pt};
    vals[REG_BODY_LENGTH]   = {24'd0, bl};
    vals[REG_TIMEOUT_TICKS] = tmo;
    vals[REG_HELLO_KIND]    = {24'd0, hk};
    vals[REG_STATUS_KIND]   = {24'd0, sk};
    vals[REG_SET_KIND]      = {24'd0, stk};
    settle();
    for (int i = REG_PACKET_TYPE; i <= REG_SET_KIND; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= 3'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      tracker.write_reg(3'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int count, input int unsigned max_step);
    step_max = max_step;
    repeat (count) random_event();
  endtask

  // Main sequence: reset, a directed walk through the request life cycle at
  // the reset register values, then random phases under several settings.
  initial begin
    tracker_event_t e;
    tracker.clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Hello, then the header checks: empty packet and foreign packet type
    // are silent, a bad length or a bad signature is invalid.
    send_event(CMD_HOST, host_word(tracker.cfg_hello, 32'h1234_5678, 8'd0, 8'd0, 1'b1));
    e = host_word(tracker.cfg_hello, 32'd1, 8'd0, 8'd0, 1'b1);
    e.len = 8'd0;
    send_event(CMD_HOST, e);
    e = host_word(tracker.cfg_hello, 32'd1, 8'd0, 8'd0, 1'b1);
    e.hdr[47:40] = 8'hFF;
    send_event(CMD_HOST, e);
    e = host_word(tracker.cfg_hello, 32'd1, 8'd0, 8'd0, 1'b1);
    e.len = 8'hFF;
    send_event(CMD_HOST, e);
    e = host_word(tracker.cfg_hello, 32'd1, 8'd0, 8'd0, 1'b1);
    e.hdr[0] = ~e.hdr[0];
    send_event(CMD_HOST, e);
    // A query for an unknown id, an unmappable feature and a zero id.
    send_event(CMD_HOST, host_word(tracker.cfg_query, 32'h55, 8'd0, 8'd0, 1'b1));
    send_event(CMD_HOST, host_word(tracker.cfg_set, 32'hA, 8'd5, 8'd1, 1'b1));
    send_event(CMD_HOST, host_word(tracker.cfg_set, 32'd0, 8'd1, 8'd1, 1'b1));
    // Queue full, then the same id again as a duplicate.
    send_event(CMD_HOST, host_word(tracker.cfg_set, 32'hFFFF_FFFF, 8'd1, 8'd1, 1'b0));
    send_event(CMD_HOST, host_word(tracker.cfg_set, 32'hFFFF_FFFF, 8'd1, 8'd2, 1'b1));
    // A queued request: a second set is busy, the query reports queued.
    send_event(CMD_HOST, host_word(tracker.cfg_set, 32'd1, 8'd4, 8'd1, 1'b1));
    send_event(CMD_HOST, host_word(tracker.cfg_set, 32'd2, 8'd2, 8'd1, 1'b1));
    send_event(CMD_HOST, host_word(tracker.cfg_query, 32'd1, 8'd0, 8'd0, 1'b1));
    // Transmit check on a foreign frame, then on ours; transmission starts
    // and the reply frame matches.
    e = frame_word(1'b0);
    e.data[0] = ~e.data[0];
    send_event(CMD_PRE_TX, e);
    send_event(CMD_PRE_TX, frame_word(1'b0));
    e = blank_event();
    e.api = 8'd2;
    send_event(CMD_TX_END, e);
    send_event(CMD_POLL, blank_event());
    send_event(CMD_RX, frame_word(1'b0));
    send_event(CMD_RX, frame_word(1'b1));
    send_event(CMD_POLL, blank_event());
    // A high mailbox number means the transmission failed.
    send_event(CMD_HOST, host_word(tracker.cfg_set, 32'd3, 8'd3, 8'd7, 1'b1));
    e = blank_event();
    e.api = 8'hFF;
    send_event(CMD_TX_END, e);
    send_event(CMD_POLL, blank_event());
    // An expired queued frame is dropped at the transmit check.
    send_event(CMD_HOST, host_word(tracker.cfg_set, 32'd4, 8'd2, 8'd2, 1'b1));
    tick = tick + 32'd2000;
    send_event(CMD_PRE_TX, frame_word(1'b0));
    send_event(CMD_POLL, blank_event());
    // Unknown command codes are ignored.
    send_event(CMD_SPARE_LO, blank_event());
    send_event(CMD_SPARE_HI, blank_event());
    // A started request that times out before its reply frame arrives.
    send_event(CMD_HOST, host_word(tracker.cfg_set, 32'd5, 8'd1, 8'd3, 1'b1));
    e = blank_event();
    e.api = 8'd0;
    send_event(CMD_TX_END, e);
    tick = tick + 32'd1500;
    send_event(CMD_RX, frame_word(1'b1));
    send_event(CMD_HOST, host_word(tracker.cfg_query, 32'd5, 8'd0, 8'd0, 1'b1));

    // Random phases. The third one starts just below the tick wrap and runs
    // without any idling; the fourth has a zero timeout, so every request is
    // found expired; the fifth has a zero body length, so no packet is
    // well-formed.
    configure(RST_PACKET_TYPE, RST_BODY_LENGTH, RST_TIMEOUT_TICKS,
              RST_HELLO_KIND, RST_STATUS_KIND, RST_SET_KIND);
    run_phase(330, 40);
    configure(8'hFF, 8'hFF, 32'd1, 8'hFF, 8'h00, 8'h80);
    run_phase(300, 3);
    tick = 32'hFFFF_FC00;
    calm = 1'b1;
    configure(8'h5A, RST_BODY_LENGTH, 32'hFFFF_FFFF, 8'h00, 8'hFF, 8'h00);
    run_phase(300, 200);
    calm = 1'b0;
    tick = $urandom;
    configure(8'h00, RST_BODY_LENGTH, 32'd0, RST_HELLO_KIND, RST_STATUS_KIND, RST_SET_KIND);
    run_phase(250, 10);
    configure(8'h00, 8'd0, 32'd300, RST_HELLO_KIND, RST_STATUS_KIND, RST_SET_KIND);
    run_phase(100, 10);
    tick = $urandom;
    configure(8'($urandom), 8'($urandom_range(1, 255)), 32'($urandom_range(1, 5000)),
              8'($urandom), 8'($urandom), 8'($urandom));
    run_phase(300, 30);
    configure(RST_PACKET_TYPE, RST_BODY_LENGTH, 32'd600,
              RST_HELLO_KIND, RST_STATUS_KIND, RST_SET_KIND);
    run_phase(300, 20);

    settle();
    if (tracker.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Watchdog: a correct run takes a small fraction of this time.
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: files.f
hdl/cansrt_pkg.sv
hdl/can_setting_request_tracker_top.sv
verif/tb_can_setting_request_tracker_top.sv
